/* rtl/core/pbg_pkg.sv */
// ----------------------------------------------------------------------------
// pbg_pkg
// Shared widths, latencies, register codes and item records for the
// planar array beam gain block.
// ----------------------------------------------------------------------------
package pbg_pkg;

    // default element cap
    localparam int MAX_ELEMENTS_DEF = 1024;

    // field widths
    localparam int ELEM_W  = 11;
    localparam int SPC_W   = 24;
    localparam int C_W     = 20;
    localparam int NORM_W  = 48;
    localparam int FREQ_W  = 24;
    localparam int COS_W   = 16;
    localparam int GAIN_W  = 48;
    localparam int CFG_IW  = 3;
    localparam int IN_DW   = 120;
    localparam int OUT_DW  = 48;

    // queue between front and back, power of two
    localparam int QDEPTH  = 4;

    // pipeline depths
    localparam int PH_NW   = 80;   // phase dividend bits, one per stage
    localparam int PH_QW   = 33;   // phase bits kept
    localparam int SIN_LAT = 9;    // fold, square, six horner steps, scale
    localparam int FAC_NW  = 32;   // factor quotient bits
    localparam int DIR_NW  = 48;   // directivity quotient bits
    localparam int AX_LAT  = 3 + PH_NW + SIN_LAT + 2 + FAC_NW + 1;
    localparam int DIR_LAT = 5 + DIR_NW;
    localparam int DIR_PAD = AX_LAT - DIR_LAT;

    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [32:0]       ONE_Q32  = 33'h1_0000_0000;

    // q30 taylor coefficients of sin(pi t)/t
    localparam logic [32:0] SIN_COEF [7] = '{
        33'd3373259426, 33'd5548789400, 33'd2738217788, 33'd643455389,
        33'd88203474,   33'd7913940,    33'd500689
    };

    // register indexes
    typedef enum logic [CFG_IW-1:0] {
        REG_ELEM_UP    = 3'd0,
        REG_ELEM_RIGHT = 3'd1,
        REG_SPC_UP     = 3'd2,
        REG_SPC_RIGHT  = 3'd3,
        REG_BAFFLE     = 3'd4,
        REG_SPEED      = 3'd5,
        REG_NORM       = 3'd6
    } t_reg_idx;

    // per-item control carried beside the datapath
    typedef struct packed {
        logic func;
        logic zero;   // back half-plane with baffle on
        logic csat;   // sound speed zero
        logic dsat;   // directivity divisor not positive
    } t_ctl;

    // classified item held in the queue
    typedef struct packed {
        t_ctl              ctl;
        logic [FREQ_W-1:0] freq;
        logic [15:0]       tu;    // |arrival_up - steer_up|
        logic [15:0]       tr;    // |arrival_right - steer_right|
        logic [14:0]       sfm;   // steer_front when positive
    } t_item;

endpackage

/* rtl/core/planar_array_beam_gain.sv */
// ----------------------------------------------------------------------------
// planar_array_beam_gain
// Planar beam gain and directivity, fixed point, one item per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one frequency with arrival and steering cosines; tuser
//  selects beam gain (0) or directivity (1). m_axis returns the 48-bit gain
//  with the saturated flag in tuser, one result per input transaction.
//  The cfg channel writes the seven registers by index; it is always ready
//  and must only be used while no transaction is in flight.
//  Throughput: one transaction per cycle while m_axis_tready stays high.
//  Path: an item passes through the input queue, then the back pipeline
//  (the 80-stage phase divider, the 9-stage sine and the 32-stage ratio
//  divider among its stages), then the output register.
//  When the receiver stalls the whole back pipeline holds; the 4-entry input
//  queue keeps accepting until full, then s_axis_tready drops.
//  Reset clears the queue and pipeline valid bits and loads the register
//  defaults.
// ----------------------------------------------------------------------------
module planar_array_beam_gain #(
    parameter int MAX_ELEMENTS = pbg_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // frequency[23:0], arrival_front, arrival_up, arrival_right,
    // steer_front, steer_up, steer_right (16 bits each)
    input  logic [pbg_pkg::IN_DW-1:0]  s_axis_tdata,
    // func
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // gain[47:0]
    output logic [pbg_pkg::OUT_DW-1:0] m_axis_tdata,
    // saturated
    output logic                       m_axis_tuser,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pbg_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [pbg_pkg::NORM_W-1:0] i_cfg_data
);
    import pbg_pkg::*;

    localparam logic [ELEM_W-1:0] N_CAP = ELEM_W'(MAX_ELEMENTS);

    logic [ELEM_W-1:0] r_elem_up, r_elem_right, w_n_up, w_n_right;
    logic [SPC_W-1:0]  r_spc_up, r_spc_right;
    logic              r_baffle;
    logic [C_W-1:0]    r_speed;
    logic [NORM_W-1:0] r_norm;

    logic              w_head_valid, w_en, w_pop;
    t_item             w_head;
    logic [32:0]       w_fu, w_fr;
    logic [GAIN_W-1:0] w_dq;
    logic              w_dovf;
    logic [65:0]       w_prod;
    logic [AX_LAT-1:0] r_vld;
    t_ctl              r_ctl [AX_LAT];
    t_ctl              w_ctl;
    logic              r_out_valid;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic              r_sat, n_sat;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_up    <= ELEM_W'(1);
            r_elem_right <= ELEM_W'(1);
            r_spc_up     <= SPC_W'(65536);
            r_spc_right  <= SPC_W'(65536);
            r_baffle     <= 1'b0;
            r_speed      <= C_W'(384000);
            r_norm       <= NORM_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ELEM_UP:    r_elem_up    <= i_cfg_data[ELEM_W-1:0];
                REG_ELEM_RIGHT: r_elem_right <= i_cfg_data[ELEM_W-1:0];
                REG_SPC_UP:     r_spc_up     <= i_cfg_data[SPC_W-1:0];
                REG_SPC_RIGHT:  r_spc_right  <= i_cfg_data[SPC_W-1:0];
                REG_BAFFLE:     r_baffle     <= i_cfg_data[0];
                REG_SPEED:      r_speed      <= i_cfg_data[C_W-1:0];
                REG_NORM:       r_norm       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // element counts capped
    assign w_n_up    = (32'(r_elem_up) > 32'(MAX_ELEMENTS)) ? N_CAP : r_elem_up;
    assign w_n_right = (32'(r_elem_right) > 32'(MAX_ELEMENTS)) ? N_CAP : r_elem_right;

    // front end and queue
    pbg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_func   (s_axis_tuser),
        .i_baffle (r_baffle),
        .i_speed  (r_speed),
        .i_norm   (r_norm),
        .o_valid  (w_head_valid),
        .i_pop    (w_pop),
        .o_item   (w_head)
    );

    // back pipeline advances whenever the output register can move
    assign w_en  = !r_out_valid || m_axis_tready;
    assign w_pop = w_en && w_head_valid;

    pbg_axis u_axis_up (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_n       (w_n_up),
        .i_spacing (r_spc_up),
        .i_freq    (w_head.freq),
        .i_tabs    (w_head.tu),
        .i_speed   (r_speed),
        .o_factor  (w_fu)
    );

    pbg_axis u_axis_right (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_n       (w_n_right),
        .i_spacing (r_spc_right),
        .i_freq    (w_head.freq),
        .i_tabs    (w_head.tr),
        .i_speed   (r_speed),
        .o_factor  (w_fr)
    );

    pbg_dir u_dir (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_freq   (w_head.freq),
        .i_sfm    (w_head.sfm),
        .i_speed  (r_speed),
        .i_norm   (r_norm),
        .i_baffle (r_baffle),
        .o_quo    (w_dq),
        .o_ovf    (w_dovf)
    );

    // valid bits and control beside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[AX_LAT-2:0], w_head_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl[0] <= w_head.ctl;
            for (int k = 1; k < AX_LAT; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // combine the factors and pick the result
    assign w_ctl  = r_ctl[AX_LAT-1];
    assign w_prod = w_fu * w_fr;

    always_comb begin
        n_gain = {14'b0, w_prod[65:32]};
        n_sat  = 1'b0;
        priority if (!w_ctl.func && w_ctl.zero) begin
            n_gain = '0;
        end else if (!w_ctl.func && w_ctl.csat) begin
            n_gain = GAIN_MAX;
            n_sat  = 1'b1;
        end else if (!w_ctl.func) begin
            n_gain = {14'b0, w_prod[65:32]};
        end else if (w_ctl.dsat || w_dovf) begin
            n_gain = GAIN_MAX;
            n_sat  = 1'b1;
        end else begin
            n_gain = w_dq;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[AX_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gain <= n_gain;
            r_sat  <= n_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_gain;
    assign m_axis_tuser  = r_sat;

    // checks
    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_head_valid)
        else $error("accepted transaction missing from queue");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == GAIN_MAX))
        else $error("saturated result not at full scale");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule

/* rtl/core/pbg_front.sv */
// ----------------------------------------------------------------------------
// pbg_front
// Accepts input transactions, classifies the special cases and buffers the
// classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module pbg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [pbg_pkg::IN_DW-1:0]  i_data,
    input  logic                       i_func,
    input  logic                       i_baffle,
    input  logic [pbg_pkg::C_W-1:0]    i_speed,
    input  logic [pbg_pkg::NORM_W-1:0] i_norm,
    output logic                       o_valid,
    input  logic                       i_pop,
    output pbg_pkg::t_item             o_item
);
    import pbg_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    logic [FREQ_W-1:0] w_freq;
    logic [COS_W-1:0]  w_af, w_au, w_ar, w_sf, w_su, w_sr;
    logic [16:0]       w_du, w_dr, w_adu, w_adr;
    t_item             w_item;
    logic              w_push;

    t_item             r_q [QDEPTH];
    logic [QAW-1:0]    r_wp, r_rp;
    logic [QCW-1:0]    r_cnt;

    // unpack fields
    assign w_freq = i_data[23:0];
    assign w_af   = i_data[39:24];
    assign w_au   = i_data[55:40];
    assign w_ar   = i_data[71:56];
    assign w_sf   = i_data[87:72];
    assign w_su   = i_data[103:88];
    assign w_sr   = i_data[119:104];

    // direction differences and magnitudes
    assign w_du  = {w_au[15], w_au} - {w_su[15], w_su};
    assign w_dr  = {w_ar[15], w_ar} - {w_sr[15], w_sr};
    assign w_adu = w_du[16] ? (17'd0 - w_du) : w_du;
    assign w_adr = w_dr[16] ? (17'd0 - w_dr) : w_dr;

    // classification
    always_comb begin
        w_item.ctl.func = i_func;
        w_item.ctl.zero = i_baffle && (w_af[15] || (w_af == '0));
        w_item.ctl.csat = (i_speed == '0);
        w_item.ctl.dsat = w_sf[15] || (w_sf == '0) || (w_freq == '0) || (i_norm == '0);
        w_item.freq     = w_freq;
        w_item.tu       = w_adu[15:0];
        w_item.tr       = w_adr[15:0];
        w_item.sfm      = w_sf[14:0];
    end

    assign o_ready = (r_cnt != QCW'(QDEPTH));
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/pbg_udiv.sv */
// ----------------------------------------------------------------------------
// pbg_udiv
// Pipelined restoring divider, one dividend bit per stage. Gives the low
// quotient bits of (rem*2^NW + num) / den; rem must be below den.
// ----------------------------------------------------------------------------
module pbg_udiv #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [QW-1:0] r_quo [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0] num_in;
        logic [DW-1:0] rem_in, den_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   wide, diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign num_in = i_num;
            assign rem_in = i_rem;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign num_in = r_num[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        // shift in one bit, subtract when it fits
        assign wide = {rem_in, num_in[NW-1]};
        assign diff = wide - {1'b0, den_in};
        assign ge   = (wide >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {num_in[NW-2:0], 1'b0};
                r_rem[k] <= ge ? diff[DW-1:0] : wide[DW-1:0];
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

/* rtl/core/pbg_axis.sv */
// ----------------------------------------------------------------------------
// pbg_axis
// Line-array factor (sin(N x)/(N sin x))^2 for one axis: phase products,
// pipelined phase divisions, polynomial sines and a pipelined ratio divide.
// ----------------------------------------------------------------------------
module pbg_axis (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [pbg_pkg::ELEM_W-1:0] i_n,
    input  logic [pbg_pkg::SPC_W-1:0]  i_spacing,
    input  logic [pbg_pkg::FREQ_W-1:0] i_freq,
    input  logic [15:0]                i_tabs,
    input  logic [pbg_pkg::C_W-1:0]    i_speed,
    output logic [32:0]                o_factor
);
    import pbg_pkg::*;

    localparam int ND = PH_NW + SIN_LAT;

    logic [47:0]       w_sf;
    logic [63:0]       w_base;
    logic [74:0]       w_bn;
    logic [47:0]       r_sf;
    logic [15:0]       r_tabs;
    logic [ELEM_W-1:0] r_n1, r_n2;
    logic [63:0]       r_base, r_base3;
    logic [74:0]       r_bn;
    logic [ELEM_W-1:0] r_nd [ND+1];
    logic [PH_QW-1:0]  w_ph [2];
    logic [47:0]       w_s [2];

    // phase products
    assign w_sf   = i_spacing * i_freq;
    assign w_base = r_sf * r_tabs;
    assign w_bn   = r_base * r_n2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sf    <= w_sf;
            r_tabs  <= i_tabs;
            r_n1    <= i_n;
            r_base  <= w_base;
            r_n2    <= r_n1;
            r_bn    <= w_bn;
            r_base3 <= r_base;
            r_nd[0] <= r_n2;
            for (int k = 1; k <= ND; k++) begin
                r_nd[k] <= r_nd[k-1];
            end
        end
    end

    // phase of x and of N x in half-turns
    pbg_udiv #(.NW(PH_NW), .DW(C_W), .QW(PH_QW)) u_div_p1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({11'b0, r_base3, 5'b0}),
        .i_rem ('0),
        .i_den (i_speed),
        .o_quo (w_ph[0])
    );

    pbg_udiv #(.NW(PH_NW), .DW(C_W), .QW(PH_QW)) u_div_pn (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({r_bn, 5'b0}),
        .i_rem ('0),
        .i_den (i_speed),
        .o_quo (w_ph[1])
    );

    // sine magnitudes of both phases
    for (genvar j = 0; j < 2; j++) begin : g_sin
        logic [31:0] t_raw, w_fold;
        logic [63:0] w_sq;
        logic [64:0] w_tg;
        logic [31:0] r_t1, r_t2;
        logic [29:0] r_u;
        logic [32:0] r_g  [6];
        logic [31:0] r_tg [6];
        logic [29:0] r_ug [6];
        logic [32:0] n_g  [6];
        logic [47:0] r_s;

        // fold onto the first quarter turn
        assign t_raw  = w_ph[j][31:0];
        assign w_fold = (t_raw > 32'h8000_0000) ? (32'd0 - t_raw) : t_raw;
        assign w_sq   = r_t1 * r_t1;
        assign w_tg   = r_tg[5] * r_g[5];

        // horner steps, one multiply each
        always_comb begin
            logic [32:0] gi;
            logic [29:0] ui;
            logic [62:0] pr;
            for (int h = 0; h < 6; h++) begin
                gi = (h == 0) ? SIN_COEF[6] : r_g[h-1];
                ui = (h == 0) ? r_u : r_ug[h-1];
                pr = gi * ui;
                n_g[h] = SIN_COEF[5-h] - pr[62:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t1 <= w_fold;
                r_u  <= w_sq[63:34];
                r_t2 <= r_t1;
                for (int h = 0; h < 6; h++) begin
                    r_g[h]  <= n_g[h];
                    r_tg[h] <= (h == 0) ? r_t2 : r_tg[h-1];
                    r_ug[h] <= (h == 0) ? r_u : r_ug[h-1];
                end
                r_s <= w_tg[63:16];
            end
        end

        assign w_s[j] = r_s;
    end

    // ratio set-up
    logic [58:0] w_den, r_den, r_den2;
    logic [47:0] r_sn, r_sn2;
    logic        r_one;
    logic        r_oned [FAC_NW];
    logic [31:0] w_r;
    logic [63:0] w_rr;

    assign w_den = w_s[0] * r_nd[ND];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= w_den;
            r_sn   <= w_s[1];
            r_den2 <= r_den;
            r_sn2  <= r_sn;
            // zero divisor or ratio at least one both give unit factor
            r_one  <= (r_den == '0) || ({11'b0, r_sn} >= r_den);
            r_oned[0] <= r_one;
            for (int k = 1; k < FAC_NW; k++) begin
                r_oned[k] <= r_oned[k-1];
            end
        end
    end

    pbg_udiv #(.NW(FAC_NW), .DW(59), .QW(32)) u_div_r (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ('0),
        .i_rem ({11'b0, r_sn2}),
        .i_den (r_den2),
        .o_quo (w_r)
    );

    // square of the ratio
    assign w_rr = w_r * w_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_factor <= r_oned[FAC_NW-1] ? ONE_Q32 : {1'b0, w_rr[63:32]};
        end
    end

endmodule

/* rtl/core/pbg_dir.sv */
// ----------------------------------------------------------------------------
// pbg_dir
// Directivity (c/f)^2 / (steer_front * norm), halved with the baffle on:
// split products, overflow test and a pipelined divide, padded to the axis
// factor latency.
module pbg_dir (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [pbg_pkg::FREQ_W-1:0] i_freq,
    input  logic [14:0]                i_sfm,
    input  logic [pbg_pkg::C_W-1:0]    i_speed,
    input  logic [pbg_pkg::NORM_W-1:0] i_norm,
    input  logic                       i_baffle,
    output logic [pbg_pkg::GAIN_W-1:0] o_quo,
    output logic                       o_ovf
);
    import pbg_pkg::*;

    logic [39:0]  w_cc, r_cc, r_cc2, r_cc3;
    logic [47:0]  w_ff, r_ff;
    logic [14:0]  r_sf;
    logic [47:0]  r_m1, r_m2;
    logic [62:0]  w_fs, r_fs;
    logic [78:0]  w_plo, w_pmd, w_phi, r_plo, r_pmd, r_phi;
    logic [110:0] r_den, r_den5;
    logic [46:0]  r_h, r_h5;
    logic         r_ovf;
    logic         r_ovd [DIR_NW];
    logic [47:0]  w_q;
    logic [48:0]  r_pad [DIR_PAD];

    assign w_cc  = i_speed * i_speed;
    assign w_ff  = i_freq * i_freq;
    assign w_fs  = r_ff * r_sf;
    assign w_plo = r_fs * r_m2[15:0];
    assign w_pmd = r_fs * r_m2[31:16];
    assign w_phi = r_fs * r_m2[47:32];

    // products, divisor and numerator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc   <= w_cc;
            r_ff   <= w_ff;
            r_sf   <= i_sfm;
            r_m1   <= i_norm;
            r_fs   <= w_fs;
            r_cc2  <= r_cc;
            r_m2   <= r_m1;
            r_plo  <= w_plo;
            r_pmd  <= w_pmd;
            r_phi  <= w_phi;
            r_cc3  <= r_cc2;
            r_den  <= {32'b0, r_plo} + {16'b0, r_pmd, 16'b0} + {r_phi, 32'b0};
            r_h    <= i_baffle ? {1'b0, r_cc3, 6'b0} : {r_cc3, 7'b0};
            r_den5 <= r_den;
            r_h5   <= r_h;
            // quotient reaches 2^48
            r_ovf  <= ({64'b0, r_h} >= r_den);
            r_ovd[0] <= r_ovf;
            for (int k = 1; k < DIR_NW; k++) begin
                r_ovd[k] <= r_ovd[k-1];
            end
        end
    end

    pbg_udiv #(.NW(DIR_NW), .DW(111), .QW(48)) u_div_d (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ('0),
        .i_rem ({64'b0, r_h5}),
        .i_den (r_den5),
        .o_quo (w_q)
    );

    // align with the axis factors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pad[0] <= {r_ovd[DIR_NW-1], w_q};
            for (int k = 1; k < DIR_PAD; k++) begin
                r_pad[k] <= r_pad[k-1];
            end
        end
    end

    assign o_ovf = r_pad[DIR_PAD-1][48];
    assign o_quo = r_pad[DIR_PAD-1][47:0];

endmodule

/* bench/planar_array_beam_gain_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_array_beam_gain_test
// Drives beam gain and directivity transactions through the block under
// several register settings, predicts every result with a fixed-point model
// of its own and checks results in order, with random idling on both sides.
// ----------------------------------------------------------------------------

// expected results in order of acceptance
class gain_scoreboard;
    typedef struct {
        logic [47:0] gain;
        logic        sat;
    } t_result;

    t_result pending[$];
    int      errors;

    function void note_input(logic [47:0] gain, logic sat);
        t_result r;
        r.gain = gain;
        r.sat  = sat;
        pending.push_back(r);
    endfunction

    // returns a message when the result differs, empty when it matches
    function string check_result(logic [47:0] gain, logic sat);
        t_result r;
        if (pending.size() == 0)
            return $sformatf("unexpected result gain=%h sat=%b", gain, sat);
        r = pending.pop_front();
        if (r.gain !== gain || r.sat !== sat)
            return $sformatf("gain %h sat %b, expected gain %h sat %b",
                             gain, sat, r.gain, r.sat);
        return "";
    endfunction
endclass

module planar_array_beam_gain_test;
    import pbg_pkg::*;

    localparam int LATENCY   = 140;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 500;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [NORM_W-1:0] i_cfg_data = '0;

    planar_array_beam_gain DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies
    logic [10:0] n_up, n_right;
    logic [23:0] d_up, d_right;
    logic        baffle;
    logic [19:0] speed;
    logic [47:0] norm;

    gain_scoreboard board = new();
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;        // no idling near the end
    bit  long_hold = 1'b0;   // long receiver hold-off request
    bit  long_done = 1'b0;   // long hold-off already started
    int  rx_hold = 0;        // receiver hold-off cycles left

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // sine magnitude in units of 2^-46 from a phase in half-turns q32
    function automatic logic [63:0] sine_mag(logic [32:0] phase);
        logic [63:0] t, u, g;
        t = {32'd0, phase[31:0]};
        if (t > 64'h8000_0000) t = 64'h1_0000_0000 - t;
        u = (t * t) >> 34;
        g = 64'(SIN_COEF[6]);
        for (int k = 5; k >= 0; k--)
            g = 64'(SIN_COEF[k]) - ((g * u) >> 30);
        return (t * g) >> 16;
    endfunction

    // line array factor (sin(N x)/(N sin x))^2 in q32
    function automatic logic [63:0] line_factor(logic [10:0] n_raw, logic [23:0] d,
                                                 logic [23:0] f, logic [15:0] t,
                                                 logic [19:0] c);
        logic [127:0] base, p1, pn, r;
        logic [63:0]  n, s1, sn, den;
        n = (32'(n_raw) > MAX_ELEMENTS_DEF) ? 64'(MAX_ELEMENTS_DEF) : 64'(n_raw);
        base = 128'(d) * 128'(f) * 128'(t);
        p1 = (base << 5) / 128'(c);
        pn = ((base * 128'(n)) << 5) / 128'(c);
        s1 = sine_mag(p1[32:0]);
        sn = sine_mag(pn[32:0]);
        den = s1 * n;
        if (den == 0) return 64'h1_0000_0000;
        r = (128'(sn) << 32) / 128'(den);
        if (r >= 128'h1_0000_0000) return 64'h1_0000_0000;
        return 64'((r * r) >> 32);
    endfunction

    // expected gain and flag for one transaction
    task automatic predict_gain(logic func, logic [IN_DW-1:0] data,
                                output logic [47:0] gain, output logic sat);
        logic [23:0] f;
        logic signed [16:0] af, au, ar, sf, su, sr, du, dr;
        logic [63:0] fu, fr;
        logic [255:0] num, den, q;
        f  = data[23:0];
        af = $signed(data[39:24]);  au = $signed(data[55:40]);
        ar = $signed(data[71:56]);  sf = $signed(data[87:72]);
        su = $signed(data[103:88]); sr = $signed(data[119:104]);
        gain = '0;
        sat = 1'b0;
        if (func == 1'b0) begin
            if (baffle && af <= 0) begin
                gain = '0;
            end else if (speed == 0) begin
                gain = GAIN_MAX; sat = 1'b1;
            end else begin
                du = au - su; dr = ar - sr;
                if (du < 0) du = -du;
                if (dr < 0) dr = -dr;
                fu = line_factor(n_up, d_up, f, du[15:0], speed);
                fr = line_factor(n_right, d_right, f, dr[15:0], speed);
                gain = (fu >= 64'h1_0000_0000) ? fr[47:0] : 48'((fu * fr) >> 32);
            end
        end else begin
            if (sf <= 0 || f == 0 || norm == 0) begin
                gain = GAIN_MAX; sat = 1'b1;
            end else begin
                num = (256'(speed) * 256'(speed)) << (baffle ? 54 : 55);
                den = 256'(f) * 256'(f) * 256'(sf[15:0]) * 256'(norm);
                q = num / den;
                if (q > 256'(GAIN_MAX)) begin
                    gain = GAIN_MAX; sat = 1'b1;
                end else begin
                    gain = q[47:0];
                end
            end
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ELEM_UP:    n_up    = value[10:0];
            REG_ELEM_RIGHT: n_right = value[10:0];
            REG_SPC_UP:     d_up    = value[23:0];
            REG_SPC_RIGHT:  d_right = value[23:0];
            REG_BAFFLE:     baffle  = value[0];
            REG_SPEED:      speed   = value[19:0];
            REG_NORM:       norm    = value;
            default: ;
        endcase
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic send_item(logic func, logic [IN_DW-1:0] data);
        logic [47:0] g;
        logic        s;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_gain(func, data, g, s);
        board.note_input(g, s);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_cos();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [IN_DW-1:0] pack_item(logic [23:0] f, logic [15:0] af,
            logic [15:0] au, logic [15:0] ar, logic [15:0] sf, logic [15:0] su,
            logic [15:0] sr);
        return {sr, su, sf, ar, au, af, f};
    endfunction

    task automatic random_items(int count);
        logic [23:0] f;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: f = 24'($urandom);
                1: f = 24'($urandom_range(0, 4000));
                2: f = 24'hFFFFFF;
                default: f = 24'($urandom_range(1, 200000));
            endcase
            send_item(1'($urandom), pack_item(f, rand_cos(), rand_cos(), rand_cos(),
                      rand_cos(), rand_cos(), rand_cos()));
        end
        stop_sending();
    endtask

    // receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold && !long_done) begin
            m_axis_tready <= 1'b0;
            rx_hold <= 300;
            long_done <= 1'b1;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!calm && m_axis_tready && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 18);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            msg = board.check_result(m_axis_tdata, m_axis_tuser);
            if (msg != "") report(msg);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || rx_hold > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        n_up = 11'd1; n_right = 11'd1; d_up = 24'd65536; d_right = 24'd65536;
        baffle = 1'b0; speed = 20'd384000; norm = 48'd65536;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes and special cases
        send_item(1'b0, pack_item(24'd16000, 16'h4000, 16'h2000, 16'h1000,
                  16'h4000, 16'h0000, 16'h0000));
        send_item(1'b1, pack_item(24'd16000, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0));
        send_item(1'b1, pack_item(24'd0, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0));
        send_item(1'b1, pack_item(24'd100, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0));
        send_item(1'b1, pack_item(24'd1, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0));
        stop_sending();
        drain();
        write_reg(REG_ELEM_UP, 48'd2047);
        write_reg(REG_ELEM_RIGHT, 48'd1024);
        write_reg(REG_SPC_UP, 48'hFFFFFF);
        write_reg(REG_SPC_RIGHT, 48'd0);
        write_reg(REG_BAFFLE, 48'd1);
        write_reg(REG_SPEED, 48'd1);
        write_reg(REG_NORM, 48'hFFFF_FFFF_FFFF);
        send_item(1'b0, pack_item(24'hFFFFFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h7FFF, 16'h8000, 16'h7FFF));
        send_item(1'b0, pack_item(24'hFFFFFF, 16'h0001, 16'h7FFF, 16'h8000,
                  16'h7FFF, 16'h8000, 16'h7FFF));
        send_item(1'b0, pack_item(24'd0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
        send_item(1'b1, pack_item(24'hFFFFFF, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0));
        stop_sending();
        drain();
        write_reg(REG_SPEED, 48'd0);
        write_reg(REG_NORM, 48'd0);
        send_item(1'b0, pack_item(24'd5000, 16'h4000, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0));
        send_item(1'b1, pack_item(24'd5000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0));
        stop_sending();
        drain();

        // random phases over several settings, long hold-off in the first
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_ELEM_UP, 48'($urandom_range(0, 2047)));
            write_reg(REG_ELEM_RIGHT, (phase == 1) ? 48'd1 : 48'($urandom_range(1, 64)));
            write_reg(REG_SPC_UP, 48'($urandom_range(0, 24'hFFFFFF)));
            write_reg(REG_SPC_RIGHT, 48'($urandom_range(1000, 200000)));
            write_reg(REG_BAFFLE, 48'(phase % 2));
            write_reg(REG_SPEED, (phase == 2) ? 48'hFFFFF : 48'($urandom_range(1, 20'hFFFFF)));
            write_reg(REG_NORM, {16'($urandom), 32'($urandom)} >> $urandom_range(0, 47));
            if (phase == 0) long_hold = 1'b1;
            if (phase == 4) calm = 1'b1;
            random_items(N_RANDOM / 5);
            drain();
        end

        if (mismatches == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
